// File: hdl/key_debounce_command_decoder_top_assert.svh
`ifndef KEY_DEBOUNCE_COMMAND_DECODER_TOP_ASSERT_SVH
`define KEY_DEBOUNCE_COMMAND_DECODER_TOP_ASSERT_SVH

// Assertion helpers; expect clk and rst in scope.

`define KDCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define KDCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/kdcd_pkg.sv
package kdcd_pkg;

  typedef logic [1:0] code_t;
  typedef logic [1:0] cmd_t;

  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_START = 2'd1;
  localparam code_t CODE_STOP  = 2'd2;
  localparam code_t CODE_CLEAR = 2'd3;

  localparam cmd_t CMD_NONE = 2'd0;
  localparam cmd_t CMD_RUN  = 2'd1;
  localparam cmd_t CMD_HALT = 2'd2;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd3;
  localparam logic [3:0] RUN_FULL       = 4'd15;

  typedef struct packed {
    logic  fire;
    code_t code;
  } key_status_t;

  typedef struct packed {
    logic safe_prev;
    logic safe_next;
  } safety_status_t;

  // key two is active low; only a single pressed key yields a code
  function automatic code_t key_code(input logic k1, input logic k2, input logic k3);
    logic [2:0] pat;
    pat = {k3, ~k2, k1};
    unique case (pat)
      3'b001:  key_code = CODE_START;
      3'b010:  key_code = CODE_STOP;
      3'b100:  key_code = CODE_CLEAR;
      default: key_code = CODE_NONE;
    endcase
  endfunction

endpackage

// File: hdl/kdcd_channels.sv
interface kdcd_key_if;
  logic valid;
  logic ready;
  logic key_one_pin;
  logic key_two_pin;
  logic key_three_pin;
  logic safety_pin;

  modport source (output valid, key_one_pin, key_two_pin, key_three_pin, safety_pin,
                  input ready);
  modport sink (input valid, key_one_pin, key_two_pin, key_three_pin, safety_pin,
                output ready);
endinterface

interface kdcd_result_if;
  logic            valid;
  logic            ready;
  kdcd_pkg::cmd_t  command;
  logic            beep_request;
  logic            clear_request;
  logic            safety_alarm;
  logic            safe_state;

  modport source (output valid, command, beep_request, clear_request, safety_alarm,
                  safe_state, input ready);
  modport sink (input valid, command, beep_request, clear_request, safety_alarm,
                safe_state, output ready);
endinterface

// File: hdl/kdcd_key_debounce.sv
module kdcd_key_debounce (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  key_one_pin,
  input  logic                  key_two_pin,
  input  logic                  key_three_pin,
  input  logic [7:0]            debounce_count,
  output kdcd_pkg::key_status_t status
);

  kdcd_pkg::code_t previous_code, previous_code_next, code;
  logic [7:0]      hold_count, hold_count_next;
  logic            press_fired, press_fired_next;
  logic            fire;

  always_comb begin
    code               = kdcd_pkg::key_code(key_one_pin, key_two_pin, key_three_pin);
    fire               = 1'b0;
    hold_count_next    = hold_count;
    press_fired_next   = press_fired;
    previous_code_next = code;
    if (code != kdcd_pkg::CODE_NONE && code == previous_code) begin
      if (!press_fired) begin
        if (hold_count < debounce_count) begin
          hold_count_next = hold_count + 8'd1;
        end else begin
          fire             = 1'b1;
          hold_count_next  = 8'd0;
          press_fired_next = 1'b1;
        end
      end
    end else begin
      hold_count_next  = 8'd0;
      press_fired_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code <= kdcd_pkg::CODE_NONE;
      hold_count    <= 8'd0;
      press_fired   <= 1'b0;
    end else if (step) begin
      previous_code <= previous_code_next;
      hold_count    <= hold_count_next;
      press_fired   <= press_fired_next;
    end
  end

  assign status.fire = fire;
  assign status.code = code;

endmodule

// File: hdl/kdcd_safety_filter.sv
module kdcd_safety_filter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     safety_pin,
  output kdcd_pkg::safety_status_t status
);

  logic       safety_sample, safety_sample_next;
  logic [3:0] safety_run, safety_run_next;
  logic       safe_latched, safe_latched_next;
  logic       level;

  always_comb begin
    level              = ~safety_pin;
    safety_sample_next = safety_sample;
    safety_run_next    = safety_run;
    safe_latched_next  = safe_latched;
    if (level == safety_sample) begin
      if (safety_run == kdcd_pkg::RUN_FULL) begin
        safe_latched_next = safety_sample;
      end else begin
        safety_run_next = safety_run + 4'd1;
      end
    end else begin
      safety_sample_next = level;
      safety_run_next    = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_sample <= 1'b0;
      safety_run    <= 4'd0;
      safe_latched  <= 1'b0;
    end else if (step) begin
      safety_sample <= safety_sample_next;
      safety_run    <= safety_run_next;
      safe_latched  <= safe_latched_next;
    end
  end

  assign status.safe_prev = safe_latched;
  assign status.safe_next = safe_latched_next;

endmodule

// File: hdl/key_debounce_command_decoder_top.sv
// Key debouncer and command decoder, one scan tick per transfer.
// Each tick passes the input register, then the result register, on its way to a result transfer.
// Throughput: one transfer per cycle; a stalled result holds off input once the input
// register also holds a tick.
// Reset (rst, synchronous): pipeline empty, debounce_count = 3, debounce and
// safety filter state cleared, safe state latched as not safe.
`include "key_debounce_command_decoder_top_assert.svh"

module key_debounce_command_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  kdcd_key_if.sink      keys,
  kdcd_result_if.source result
);

  logic       in_valid;
  logic       k1, k2, k3, sp;
  logic       out_valid;
  logic       advance;
  logic [7:0] debounce_count;

  kdcd_pkg::key_status_t    key_st;
  kdcd_pkg::safety_status_t safe_st;

  kdcd_pkg::cmd_t command, command_next;
  logic           beep, beep_next;
  logic           clr, clr_next;
  logic           alarm, alarm_next;
  logic           safe, safe_next;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign keys.ready = !in_valid || !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= kdcd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (keys.valid && keys.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      k1 <= keys.key_one_pin;
      k2 <= keys.key_two_pin;
      k3 <= keys.key_three_pin;
      sp <= keys.safety_pin;
    end
  end

  kdcd_key_debounce u_key (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .key_one_pin    (k1),
    .key_two_pin    (k2),
    .key_three_pin  (k3),
    .debounce_count (debounce_count),
    .status         (key_st)
  );

  kdcd_safety_filter u_safety (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .safety_pin (sp),
    .status     (safe_st)
  );

  always_comb begin
    command_next = kdcd_pkg::CMD_NONE;
    beep_next    = 1'b0;
    clr_next     = 1'b0;
    alarm_next   = 1'b0;
    safe_next    = safe_st.safe_next;
    if (key_st.fire) begin
      unique case (key_st.code)
        kdcd_pkg::CODE_START: begin
          if (safe_st.safe_prev) begin
            command_next = kdcd_pkg::CMD_RUN;
            beep_next    = 1'b1;
          end else begin
            alarm_next = 1'b1;
          end
        end
        kdcd_pkg::CODE_STOP: begin
          command_next = kdcd_pkg::CMD_HALT;
          beep_next    = 1'b1;
        end
        kdcd_pkg::CODE_CLEAR: clr_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command <= command_next;
      beep    <= beep_next;
      clr     <= clr_next;
      alarm   <= alarm_next;
      safe    <= safe_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.command       = command;
  assign result.beep_request  = beep;
  assign result.clear_request = clr;
  assign result.safety_alarm  = alarm;
  assign result.safe_state    = safe;

  `KDCD_ASSERT_NOW(a_cmd_beeps, out_valid && command != kdcd_pkg::CMD_NONE, beep, "no beep")
  `KDCD_ASSERT_NOW(a_one_action, out_valid, $onehot0({beep, clr, alarm}), "more than one action")
  `KDCD_ASSERT_NEXT(a_hold_stalled, in_valid && !advance, in_valid, "pending tick dropped")
  `KDCD_ASSERT_NOW(a_fire_has_code, key_st.fire, key_st.code != kdcd_pkg::CODE_NONE, "fire on no key")

endmodule

// File: bench/key_command_checker.sv
module key_command_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  kdcd_key_if        keys,
  kdcd_result_if     result,
  output int         fail_count,
  output int         waiting,
  output int         n_start,
  output int         n_stop,
  output int         n_clear,
  output int         n_refused
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kdcd_pkg::cmd_t command;
    logic beep;
    logic clr;
    logic alarm;
    logic safe;
  } tick_action_t;

  typedef struct {
    kdcd_pkg::code_t last_code;
    logic [7:0]      held;
    logic            fired;
    logic            sample;
    logic [3:0]      run;
    logic            safe;
  } scan_state_t;

  logic [7:0]   debounce;
  scan_state_t  scan;
  tick_action_t actions_due[$];

  function automatic kdcd_pkg::code_t pin_code(input logic k1, input logic k2,
                                               input logic k3);
    if (k1 && k2 && !k3) return kdcd_pkg::CODE_START;
    if (!k1 && !k2 && !k3) return kdcd_pkg::CODE_STOP;
    if (!k1 && k2 && k3) return kdcd_pkg::CODE_CLEAR;
    return kdcd_pkg::CODE_NONE;
  endfunction

  function automatic void scan_tick(input logic k1, input logic k2, input logic k3,
                                    input logic sp);
    kdcd_pkg::code_t c;
    logic            fire;
    logic            level;
    tick_action_t    act;
    c = pin_code(k1, k2, k3);
    fire = 1'b0;
    act = '0;
    if (c != kdcd_pkg::CODE_NONE && c == scan.last_code) begin
      if (!scan.fired) begin
        if (scan.held < debounce) begin
          scan.held = scan.held + 8'd1;
        end else begin
          fire = 1'b1;
          scan.held = '0;
          scan.fired = 1'b1;
        end
      end
    end else begin
      scan.fired = 1'b0;
      scan.held = '0;
    end
    scan.last_code = c;
    // start decision sees the latch from before this tick
    if (fire) begin
      case (c)
        kdcd_pkg::CODE_START: begin
          if (scan.safe) begin
            act.command = kdcd_pkg::CMD_RUN;
            act.beep = 1'b1;
          end else begin
            act.alarm = 1'b1;
          end
        end
        kdcd_pkg::CODE_STOP: begin
          act.command = kdcd_pkg::CMD_HALT;
          act.beep = 1'b1;
        end
        kdcd_pkg::CODE_CLEAR: act.clr = 1'b1;
        default: ;
      endcase
    end
    level = ~sp;
    if (level == scan.sample) begin
      if (scan.run == kdcd_pkg::RUN_FULL) scan.safe = scan.sample;
      else scan.run = scan.run + 4'd1;
    end else begin
      scan.sample = level;
      scan.run = '0;
    end
    act.safe = scan.safe;
    actions_due.push_back(act);
  endfunction

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    tick_action_t want;
    if (rst) begin
      debounce = kdcd_pkg::DEBOUNCE_RESET;
      scan = '{kdcd_pkg::CODE_NONE, 8'd0, 1'b0, 1'b0, 4'd0, 1'b0};
      actions_due.delete();
      fail_count = 0;
      n_start = 0;
      n_stop = 0;
      n_clear = 0;
      n_refused = 0;
    end else begin
      if (cfg_we) debounce = cfg_data;
      if (keys.valid && keys.ready)
        scan_tick(keys.key_one_pin, keys.key_two_pin, keys.key_three_pin, keys.safety_pin);
      if (result.valid && result.ready) begin
        if (actions_due.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = actions_due.pop_front();
          check_field("command", want.command, result.command);
          check_field("beep_request", {1'b0, want.beep}, {1'b0, result.beep_request});
          check_field("clear_request", {1'b0, want.clr}, {1'b0, result.clear_request});
          check_field("safety_alarm", {1'b0, want.alarm}, {1'b0, result.safety_alarm});
          check_field("safe_state", {1'b0, want.safe}, {1'b0, result.safe_state});
          if (want.command == kdcd_pkg::CMD_RUN) n_start++;
          if (want.command == kdcd_pkg::CMD_HALT) n_stop++;
          if (want.clr) n_clear++;
          if (want.alarm) n_refused++;
        end
      end
    end
    waiting = actions_due.size();
  end

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic k1;
    logic k2;
    logic k3;
    logic sp;
  } scan_pins_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  kdcd_key_if    keys_ch ();
  kdcd_result_if res_ch ();

  int fail_count;
  int waiting;
  int n_start;
  int n_stop;
  int n_clear;
  int n_refused;

  bit   tx_idle_on;
  bit   rx_stall_on;
  bit   glitch_on;
  int   long_hold_req;
  int   ticks_sent;
  int   dbn;
  logic safety_level;

  always #6 clk = ~clk;

  key_debounce_command_decoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .keys     (keys_ch),
    .result   (res_ch)
  );

  key_command_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .keys       (keys_ch),
    .result     (res_ch),
    .fail_count (fail_count),
    .waiting    (waiting),
    .n_start    (n_start),
    .n_stop     (n_stop),
    .n_clear    (n_clear),
    .n_refused  (n_refused)
  );

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : result_receiver
    int stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        stall_left = long_hold_req;
        long_hold_req = 0;
      end else if (stall_left == 0 && rx_stall_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic safety_now();
    if (glitch_on && $urandom_range(0, 49) == 0) return ~safety_level;
    return safety_level;
  endfunction

  function automatic scan_pins_t pins_for(input kdcd_pkg::code_t c);
    case (c)
      kdcd_pkg::CODE_START: return {1'b1, 1'b1, 1'b0, safety_now()};
      kdcd_pkg::CODE_STOP:  return {1'b0, 1'b0, 1'b0, safety_now()};
      kdcd_pkg::CODE_CLEAR: return {1'b0, 1'b1, 1'b1, safety_now()};
      default:              return {1'b0, 1'b1, 1'b0, safety_now()};
    endcase
  endfunction

  function automatic scan_pins_t noise_pins();
    scan_pins_t p;
    p = scan_pins_t'(4'($urandom_range(0, 15)));
    p.sp = safety_now();
    return p;
  endfunction

  // called and returns at a falling edge; valid stays up for back-to-back transfers
  task automatic send_tick(input scan_pins_t p);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      keys_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    keys_ch.valid         <= 1'b1;
    keys_ch.key_one_pin   <= p.k1;
    keys_ch.key_two_pin   <= p.k2;
    keys_ch.key_three_pin <= p.k3;
    keys_ch.safety_pin    <= p.sp;
    @(posedge clk);
    while (!keys_ch.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic hold_key(input kdcd_pkg::code_t c, input int n);
    repeat (n) send_tick(pins_for(c));
  endtask

  task automatic drain();
    keys_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_episode();
    kdcd_pkg::code_t c;
    int              n;
    if ($urandom_range(0, 19) == 0) safety_level = ~safety_level;
    if ($urandom_range(0, 99) < 75) begin
      c = kdcd_pkg::code_t'($urandom_range(1, 3));
      repeat ($urandom_range(0, 2)) send_tick(noise_pins());
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, dbn + 1);
      else n = dbn + 2 + $urandom_range(0, 5);
      hold_key(c, n);
      if ($urandom_range(0, 4) != 0) hold_key(kdcd_pkg::CODE_NONE, $urandom_range(1, 4));
    end else begin
      repeat ($urandom_range(1, 6)) send_tick(noise_pins());
    end
  endtask

  task automatic run_phase(input int setting, input int n_items, input bit tx_idle,
                           input bit rx_stall, input int rx_hold);
    int target;
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= 8'(setting);
    @(negedge clk);
    cfg_we <= 1'b0;
    dbn = setting;
    tx_idle_on = tx_idle;
    rx_stall_on = rx_stall;
    long_hold_req = rx_hold;
    target = ticks_sent + n_items;
    while (ticks_sent < target) random_episode();
  endtask

  initial begin
    keys_ch.valid         = 1'b0;
    keys_ch.key_one_pin   = 1'b0;
    keys_ch.key_two_pin   = 1'b1;
    keys_ch.key_three_pin = 1'b0;
    keys_ch.safety_pin    = 1'b1;
    tx_idle_on    = 1'b1;
    rx_stall_on   = 1'b1;
    glitch_on     = 1'b0;
    long_hold_req = 0;
    ticks_sent    = 0;
    dbn           = 3;
    safety_level  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset debounce, switch not yet safe
    hold_key(kdcd_pkg::CODE_NONE, 1);
    hold_key(kdcd_pkg::CODE_START, 5);
    send_tick({1'b1, 1'b0, 1'b1, safety_level});
    hold_key(kdcd_pkg::CODE_STOP, 5);
    hold_key(kdcd_pkg::CODE_CLEAR, 6);
    send_tick({1'b1, 1'b1, 1'b1, safety_level});
    hold_key(kdcd_pkg::CODE_START, 3);
    hold_key(kdcd_pkg::CODE_STOP, 1);
    hold_key(kdcd_pkg::CODE_START, 5);
    // latch safe, then start goes through
    safety_level = 1'b0;
    hold_key(kdcd_pkg::CODE_NONE, 17);
    hold_key(kdcd_pkg::CODE_START, 5);
    send_tick({1'b0, 1'b1, 1'b0, 1'b1});
    glitch_on = 1'b1;

    run_phase(0, 220, 1'b1, 1'b1, 0);
    run_phase(1, 200, 1'b0, 1'b0, 80);
    run_phase(2, 200, 1'b1, 1'b0, 0);
    run_phase(255, 540, 1'b0, 1'b1, 0);
    run_phase($urandom_range(4, 20), 250, 1'b1, 1'b1, 0);
    run_phase(5, 200, 1'b0, 1'b0, 0);

    drain();
    repeat (4) @(negedge clk);
    $display("Sent %0d scan ticks over debounce settings 3, 0, 1, 2, 255, random and 5.",
             ticks_sent);
    $display("Presses fired: %0d start, %0d stop, %0d clear, %0d refused as unsafe.",
             n_start, n_stop, n_clear, n_refused);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
